### design/assert_macros.svh
// Assertion macros for the checker file.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define AMVL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define AMVL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/amvl_pkg.sv
// Shared types and constants for the vibration level block.
// No dependencies; used by the top level, front, queue, back end and bench.
`timescale 1ns / 1ps

package amvl_pkg;

   localparam int AXIS_W    = 13;
   localparam int AXES      = 3;
   localparam int OFFSET_W  = 12;
   localparam int ALPHA_W   = 16;
   localparam int LEVEL_W   = 29;
   localparam int REL_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 29;
   localparam int SQ_W      = 26;
   localparam int RAD_W     = 58;
   localparam int ROOT_STEPS = 29;
   localparam int QUEUE_DEPTH = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_ABS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_REL = 3'd5;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd41;
   // 1 g = 10 units of 100 mg, 16 fraction bits
   localparam logic [LEVEL_W-1:0] ONE_G = 29'(10 << 16);

   typedef struct packed {
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic signed [OFFSET_W-1:0] offset_z;
      logic [ALPHA_W-1:0]         alpha;
      logic [LEVEL_W-1:0]         thresh_abs;
      logic [REL_W-1:0]           thresh_rel;
   } cfg_type;

   // Classified word passed from front to back
   typedef struct packed {
      logic                     is_report;
      logic                     force_rep;
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MEDIAN,
      ST_SQUARE,
      ST_ROOT,
      ST_DIST,
      ST_BLEND,
      ST_REP_MUL1,
      ST_REP_MUL2,
      ST_REP_DECIDE
   } back_state_type;

endpackage

### design/amvl_interfaces.sv
// Valid/ready channel interfaces for request and response words.
// Depends on nothing.
`timescale 1ns / 1ps

interface amvl_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] x_word;
   logic [15:0] y_word;
   logic [15:0] z_word;
   logic        force_report;
   modport source (output valid, req_type, x_word, y_word, z_word, force_report,
                   input ready);
   modport sink   (input valid, req_type, x_word, y_word, z_word, force_report,
                   output ready);
endinterface

interface amvl_rsp_if;
   logic        valid;
   logic        ready;
   logic        reported;
   logic [28:0] level;
   modport source (output valid, reported, level, input ready);
   modport sink   (input valid, reported, level, output ready);
endinterface

### design/accel_median_vibration_level.sv
// Vibration level block: a sample word is stored in the back-end window; once the
// window is full it also runs median ranking, 3 squares, a 29-step square root, a
// distance step and a blend step. A report word passes through ST_REP_MUL1, ST_REP_MUL2
// and ST_REP_DECIDE, which waits for a free response slot. The back-end sequencer handles one word at a time.
// Synchronous active-high reset empties the windows, clears level and last report, and sets registers to reset values.
`timescale 1ns / 1ps

module accel_median_vibration_level #(
   parameter int MEDIAN_WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   amvl_req_if.sink    req_chan,
   amvl_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [amvl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [amvl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   amvl_pkg::cfg_type  cfg_ff, cfg_in;
   amvl_pkg::item_type push_item, pop_item;
   logic push, pop, queue_full, queue_empty;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            amvl_pkg::CSR_OFFSET_X:   cfg_in.offset_x   = csr_wdata[11:0];
            amvl_pkg::CSR_OFFSET_Y:   cfg_in.offset_y   = csr_wdata[11:0];
            amvl_pkg::CSR_OFFSET_Z:   cfg_in.offset_z   = csr_wdata[11:0];
            amvl_pkg::CSR_ALPHA:      cfg_in.alpha      = csr_wdata[15:0];
            amvl_pkg::CSR_THRESH_ABS: cfg_in.thresh_abs = csr_wdata[28:0];
            amvl_pkg::CSR_THRESH_REL: cfg_in.thresh_rel = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x   <= '0;
         cfg_ff.offset_y   <= '0;
         cfg_ff.offset_z   <= '0;
         cfg_ff.alpha      <= amvl_pkg::ALPHA_RESET;
         cfg_ff.thresh_abs <= '0;
         cfg_ff.thresh_rel <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amvl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   amvl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty)
   );

   amvl_back #(
      .MEDIAN_WINDOW (MEDIAN_WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

### design/amvl_front.sv
// Front end: accepts request words, applies axis offsets, classifies.
// Depends on amvl_pkg and amvl_req_if.
`timescale 1ns / 1ps

module amvl_front (
   input  logic                 clock,
   input  logic                 reset,
   amvl_req_if.sink             req_chan,
   input  amvl_pkg::cfg_type    cfg,
   output logic                 push,
   output amvl_pkg::item_type   push_item,
   input  logic                 queue_full
);

   logic               stage_valid_ff, stage_valid_in;
   amvl_pkg::item_type stage_ff, stage_in;
   logic               accept;

   // Stage drains into the queue whenever there is room
   assign push           = stage_valid_ff && !queue_full;
   assign push_item      = stage_ff;
   assign req_chan.ready = !stage_valid_ff || push;
   assign accept         = req_chan.valid && req_chan.ready;

   // Axis value: signed bits 15:4 plus signed offset
   always_comb begin
      stage_in.is_report = req_chan.req_type;
      stage_in.force_rep = req_chan.force_report;
      stage_in.x = 13'(signed'(req_chan.x_word[15:4])) + 13'(cfg.offset_x);
      stage_in.y = 13'(signed'(req_chan.y_word[15:4])) + 13'(cfg.offset_y);
      stage_in.z = 13'(signed'(req_chan.z_word[15:4])) + 13'(cfg.offset_z);
      stage_valid_in = accept || (stage_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

### design/amvl_fifo.sv
// Short queue between front and back ends.
// Depends on amvl_pkg.
`timescale 1ns / 1ps

module amvl_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  amvl_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output amvl_pkg::item_type pop_item,
   output logic               empty
);

   localparam int PTR_W = (amvl_pkg::QUEUE_DEPTH > 1) ? $clog2(amvl_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(amvl_pkg::QUEUE_DEPTH + 1);

   amvl_pkg::item_type mem_ff [amvl_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(amvl_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(amvl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(amvl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/amvl_back.sv
// Back end: sliding windows, rank-based median, bit-serial square root,
// level averaging and report decision with the response register.
// Depends on amvl_pkg and amvl_rsp_if.
`timescale 1ns / 1ps

module amvl_back #(
   parameter int MEDIAN_WINDOW = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  amvl_pkg::cfg_type  cfg,
   input  logic               queue_empty,
   input  amvl_pkg::item_type pop_item,
   output logic               pop,
   amvl_rsp_if.source         rsp_chan
);

   localparam int IDX_W = (MEDIAN_WINDOW > 1) ? $clog2(MEDIAN_WINDOW) : 1;
   localparam int CNT_W = $clog2(MEDIAN_WINDOW + 1);
   localparam int PROD_W = amvl_pkg::LEVEL_W + 17;

   amvl_pkg::back_state_type state_ff, state_in;
   amvl_pkg::item_type item_ff;

   logic signed [amvl_pkg::AXIS_W-1:0] win_ff [amvl_pkg::AXES][MEDIAN_WINDOW];
   logic signed [amvl_pkg::AXIS_W-1:0] med_ff [amvl_pkg::AXES];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] cand_ff;
   logic [1:0]       sq_idx_ff;
   logic [amvl_pkg::SQ_W-1:0]    sq_acc_ff;
   logic [amvl_pkg::RAD_W-1:0]   rad_ff;
   logic [amvl_pkg::LEVEL_W:0]   rem_ff;
   logic [amvl_pkg::LEVEL_W-1:0] root_ff;
   logic [4:0]       step_ff;
   logic [PROD_W-1:0] prod_ff, pc_ff, pa_ff;
   logic [amvl_pkg::LEVEL_W-1:0] avg_ff, last_ff;
   logic             rsp_valid_ff;
   logic             rsp_reported_ff;
   logic [amvl_pkg::LEVEL_W-1:0] rsp_level_ff;

   logic [CNT_W-1:0] rank [amvl_pkg::AXES];
   logic signed [2*amvl_pkg::AXIS_W-1:0] square;
   logic [amvl_pkg::LEVEL_W+2:0] rem_shift;
   logic [amvl_pkg::LEVEL_W+2:0] trial;
   logic             trial_ok;
   logic [amvl_pkg::LEVEL_W-1:0] distance;
   logic [PROD_W:0]  blend;
   logic [16:0]      scale;
   logic             slot_free;
   logic             report;
   logic             median_last;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.reported = rsp_reported_ff;
   assign rsp_chan.level    = rsp_level_ff;
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign median_last = (cand_ff == IDX_W'(MEDIAN_WINDOW - 1));

   // Fill count after storing one more value
   assign fill_in = (fill_ff == CNT_W'(MEDIAN_WINDOW)) ? fill_ff : fill_ff + 1'b1;

   // Rank of the candidate: smaller values, plus equal ones ahead of it
   always_comb begin
      for (int a = 0; a < amvl_pkg::AXES; a++) begin
         rank[a] = '0;
         for (int j = 0; j < MEDIAN_WINDOW; j++) begin
            if ((win_ff[a][j] < win_ff[a][cand_ff]) ||
                ((win_ff[a][j] == win_ff[a][cand_ff]) && (IDX_W'(j) < cand_ff))) begin
               rank[a] = rank[a] + 1'b1;
            end
         end
      end
   end

   // Shared squarer, one axis per cycle
   assign square = med_ff[sq_idx_ff] * med_ff[sq_idx_ff];

   // One result bit of the square root per cycle
   always_comb begin
      rem_shift = {rem_ff, rad_ff[amvl_pkg::RAD_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      trial_ok  = (rem_shift >= trial);
   end

   // Distance from 1 g, blend and report math
   always_comb begin
      distance = (root_ff > amvl_pkg::ONE_G) ? root_ff - amvl_pkg::ONE_G
                                             : amvl_pkg::ONE_G - root_ff;
      blend = (PROD_W+1)'(prod_ff)
            + (PROD_W+1)'((17'h10000 - 17'(cfg.alpha)) * avg_ff)
            + (PROD_W+1)'(32768);
      scale = 17'h10000 + 17'(cfg.thresh_rel);
      report = item_ff.force_rep ||
               (((avg_ff > cfg.thresh_abs) || (last_ff > cfg.thresh_abs)) &&
                (({1'b0, avg_ff, 16'h0000} > pc_ff) ||
                 ({1'b0, last_ff, 16'h0000} > pa_ff)));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amvl_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               state_in = pop_item.is_report ? amvl_pkg::ST_REP_MUL1 : amvl_pkg::ST_LOAD;
            end
         end
         amvl_pkg::ST_LOAD: begin
            state_in = (fill_in == CNT_W'(MEDIAN_WINDOW)) ? amvl_pkg::ST_MEDIAN
                                                           : amvl_pkg::ST_IDLE;
         end
         amvl_pkg::ST_MEDIAN: begin
            if (median_last) state_in = amvl_pkg::ST_SQUARE;
         end
         amvl_pkg::ST_SQUARE: begin
            if (sq_idx_ff == 2'd2) state_in = amvl_pkg::ST_ROOT;
         end
         amvl_pkg::ST_ROOT: begin
            if (step_ff == 5'(amvl_pkg::ROOT_STEPS - 1)) state_in = amvl_pkg::ST_DIST;
         end
         amvl_pkg::ST_DIST:     state_in = amvl_pkg::ST_BLEND;
         amvl_pkg::ST_BLEND:    state_in = amvl_pkg::ST_IDLE;
         amvl_pkg::ST_REP_MUL1: state_in = amvl_pkg::ST_REP_MUL2;
         amvl_pkg::ST_REP_MUL2: state_in = amvl_pkg::ST_REP_DECIDE;
         amvl_pkg::ST_REP_DECIDE: begin
            if (slot_free) state_in = amvl_pkg::ST_IDLE;
         end
         default: state_in = amvl_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      case (state_ff)
         amvl_pkg::ST_IDLE: pop = !queue_empty;
         default:           pop = 1'b0;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amvl_pkg::ST_IDLE;
         fill_ff      <= '0;
         avg_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // New response loads the slot; otherwise a taken response clears it
         if ((state_ff == amvl_pkg::ST_REP_DECIDE) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            amvl_pkg::ST_LOAD:  fill_ff <= fill_in;
            amvl_pkg::ST_BLEND: avg_ff  <= blend[16 +: amvl_pkg::LEVEL_W];
            amvl_pkg::ST_REP_DECIDE: begin
               if (slot_free && report) last_ff <= avg_ff;
            end
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         amvl_pkg::ST_IDLE: begin
            item_ff <= pop_item;
            cand_ff <= '0;
         end
         amvl_pkg::ST_LOAD: begin
            // Oldest value drops out, newest enters at the top
            for (int k = 0; k < MEDIAN_WINDOW - 1; k++) begin
               for (int a = 0; a < amvl_pkg::AXES; a++) begin
                  win_ff[a][k] <= win_ff[a][k+1];
               end
            end
            win_ff[0][MEDIAN_WINDOW-1] <= item_ff.x;
            win_ff[1][MEDIAN_WINDOW-1] <= item_ff.y;
            win_ff[2][MEDIAN_WINDOW-1] <= item_ff.z;
         end
         amvl_pkg::ST_MEDIAN: begin
            for (int a = 0; a < amvl_pkg::AXES; a++) begin
               if (rank[a] == CNT_W'(MEDIAN_WINDOW / 2)) med_ff[a] <= win_ff[a][cand_ff];
            end
            cand_ff   <= cand_ff + 1'b1;
            sq_idx_ff <= 2'd0;
            sq_acc_ff <= '0;
         end
         amvl_pkg::ST_SQUARE: begin
            sq_idx_ff <= sq_idx_ff + 2'd1;
            sq_acc_ff <= sq_acc_ff + amvl_pkg::SQ_W'(unsigned'(square));
            if (sq_idx_ff == 2'd2) begin
               rad_ff  <= {sq_acc_ff + amvl_pkg::SQ_W'(unsigned'(square)), 32'h0};
               rem_ff  <= '0;
               root_ff <= '0;
               step_ff <= '0;
            end
         end
         amvl_pkg::ST_ROOT: begin
            rad_ff  <= {rad_ff[amvl_pkg::RAD_W-3:0], 2'b00};
            step_ff <= step_ff + 5'd1;
            if (trial_ok) begin
               rem_ff  <= (amvl_pkg::LEVEL_W+1)'(rem_shift - trial);
               root_ff <= {root_ff[amvl_pkg::LEVEL_W-2:0], 1'b1};
            end else begin
               rem_ff  <= (amvl_pkg::LEVEL_W+1)'(rem_shift);
               root_ff <= {root_ff[amvl_pkg::LEVEL_W-2:0], 1'b0};
            end
         end
         amvl_pkg::ST_DIST:     prod_ff <= PROD_W'(cfg.alpha * distance);
         amvl_pkg::ST_REP_MUL1: pc_ff   <= PROD_W'(scale * last_ff);
         amvl_pkg::ST_REP_MUL2: pa_ff   <= PROD_W'(scale * avg_ff);
         amvl_pkg::ST_REP_DECIDE: begin
            if (slot_free) begin
               rsp_reported_ff <= report;
               rsp_level_ff    <= avg_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

### design/amvl_checker.sv
// Port-level checks for the vibration level block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amvl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_reported,
   input logic [28:0] rsp_level
);

   logic [29:0] rsp_word;

   assign rsp_word = {rsp_reported, rsp_level};

   // No response straight out of reset
   `AMVL_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response valid after reset")

   // A stalled response holds its contents
   `AMVL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> $stable({rsp_valid, rsp_word}), "stall")

   // Request handshake and response valid stay known once out of reset
   `AMVL_ASSERT(a_known, !$isunknown({req_valid, req_ready, rsp_valid}), "unknown handshake")

endmodule

bind accel_median_vibration_level amvl_checker u_amvl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_reported (rsp_chan.reported),
   .rsp_level    (rsp_chan.level)
);

### bench/testbench.sv
// Self-checking bench for the vibration level block: random and directed words,
// scoreboard against an in-bench level predictor.
// Depends on amvl_pkg, amvl_interfaces and the accel_median_vibration_level RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int WIN = 5;
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [amvl_pkg::LEVEL_W-1:0] LEVEL_MASK = '1;
   localparam logic [amvl_pkg::CSR_IDX_W-1:0] CSR_UNUSED_A =
      amvl_pkg::CSR_IDX_W'(int'(amvl_pkg::CSR_THRESH_REL) + 1);
   localparam logic [amvl_pkg::CSR_IDX_W-1:0] CSR_UNUSED_B =
      amvl_pkg::CSR_IDX_W'(int'(amvl_pkg::CSR_THRESH_REL) + 2);

   typedef struct {
      logic        is_report;
      logic [15:0] xw;
      logic [15:0] yw;
      logic [15:0] zw;
      logic        force_rep;
   } sample_word_type;

   typedef struct {
      logic                         reported;
      logic [amvl_pkg::LEVEL_W-1:0] level;
   } level_report_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [amvl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [amvl_pkg::CSR_DATA_W-1:0] csr_wdata;

   amvl_req_if req_chan ();
   amvl_rsp_if rsp_chan ();

   accel_median_vibration_level #(.MEDIAN_WINDOW(WIN)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state and register copy
   int                 win_x[WIN], win_y[WIN], win_z[WIN];
   int                 held;
   logic [amvl_pkg::LEVEL_W-1:0] level_q, last_rep_q;
   int                 off_x, off_y, off_z;
   logic [amvl_pkg::ALPHA_W-1:0] alpha_q;
   logic [amvl_pkg::LEVEL_W-1:0] thr_abs_q;
   logic [amvl_pkg::REL_W-1:0]   thr_rel_q;

   sample_word_type  pending_words[$];
   level_report_type expected_reports[$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  steady = 0;
   int  hold_trigger = 0;
   int  hold_seen = 0;
   int  hold_left = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic int middle_of(int w[WIN]);
      int t[WIN];
      int i, j, key;
      t = w;
      for (i = 1; i < WIN; i++) begin
         key = t[i];
         j = i - 1;
         while (j >= 0 && t[j] > key) begin
            t[j+1] = t[j];
            j--;
         end
         t[j+1] = key;
      end
      return t[WIN/2];
   endfunction

   // Advance the level predictor by one accepted word
   task automatic track_level(sample_word_type w);
      longint unsigned sq, s, d, acc, a, c, scale;
      longint mx, my, mz;
      level_report_type r;
      bit rep;
      if (!w.is_report) begin
         if (held >= WIN) held = WIN - 1;
         win_x[held] = int'($signed(w.xw[15:4])) + off_x;
         win_y[held] = int'($signed(w.yw[15:4])) + off_y;
         win_z[held] = int'($signed(w.zw[15:4])) + off_z;
         held++;
         if (held == WIN) begin
            mx = middle_of(win_x);
            my = middle_of(win_y);
            mz = middle_of(win_z);
            sq = longint'(mx*mx + my*my + mz*mz);
            s = root_floor(sq << 32);
            d = (s > 64'(amvl_pkg::ONE_G)) ? s - 64'(amvl_pkg::ONE_G)
                                           : 64'(amvl_pkg::ONE_G) - s;
            acc = 64'(alpha_q) * d + (64'd65536 - 64'(alpha_q)) * 64'(level_q) + 64'd32768;
            level_q = amvl_pkg::LEVEL_W'(acc >> 16);
            for (int k = 0; k + 1 < WIN; k++) begin
               win_x[k] = win_x[k+1];
               win_y[k] = win_y[k+1];
               win_z[k] = win_z[k+1];
            end
            held = WIN - 1;
         end
      end else begin
         a = 64'(level_q);
         c = 64'(last_rep_q);
         scale = 64'd65536 + 64'(thr_rel_q);
         rep = w.force_rep;
         if (!rep && (a > 64'(thr_abs_q) || c > 64'(thr_abs_q)))
            if (a * 65536 > c * scale || c * 65536 > a * scale) rep = 1;
         if (rep) last_rep_q = level_q;
         r.reported = rep;
         r.level = level_q & LEVEL_MASK;
         expected_reports = {expected_reports, r};
      end
   endtask

   // Request driver; also feeds the predictor on each accepted word
   always @(posedge clock) begin : req_driver
      sample_word_type w, cur;
      if (reset) begin
         req_chan.valid <= 0;
         req_chan.req_type <= 0;
         req_chan.x_word <= 0;
         req_chan.y_word <= 0;
         req_chan.z_word <= 0;
         req_chan.force_report <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            cur.is_report = req_chan.req_type;
            cur.xw = req_chan.x_word;
            cur.yw = req_chan.y_word;
            cur.zw = req_chan.z_word;
            cur.force_rep = req_chan.force_report;
            track_level(cur);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
               w = pending_words.pop_front();
               req_chan.valid <= 1;
               req_chan.req_type <= w.is_report;
               req_chan.x_word <= w.xw;
               req_chan.y_word <= w.yw;
               req_chan.z_word <= w.zw;
               req_chan.force_report <= w.force_rep;
            end else begin
               req_chan.valid <= 0;
            end
         end
      end
   end

   // Response ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= 400;
         rsp_chan.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= steady || $urandom_range(99) >= 15;
      end
   end

   // Response checker
   always @(posedge clock) begin : rsp_monitor
      level_report_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: reported=%0d level=%0d",
                        rsp_chan.reported, rsp_chan.level);
         end else begin
            e = expected_reports.pop_front();
            if (e.reported !== rsp_chan.reported || e.level !== rsp_chan.level) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp reported=%0d level=%0d, got reported=%0d level=%0d",
                           e.reported, e.level, rsp_chan.reported, rsp_chan.level);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [amvl_pkg::CSR_IDX_W-1:0] idx,
                            logic [amvl_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         amvl_pkg::CSR_OFFSET_X:   off_x = int'($signed(data[amvl_pkg::OFFSET_W-1:0]));
         amvl_pkg::CSR_OFFSET_Y:   off_y = int'($signed(data[amvl_pkg::OFFSET_W-1:0]));
         amvl_pkg::CSR_OFFSET_Z:   off_z = int'($signed(data[amvl_pkg::OFFSET_W-1:0]));
         amvl_pkg::CSR_ALPHA:      alpha_q = data[amvl_pkg::ALPHA_W-1:0];
         amvl_pkg::CSR_THRESH_ABS: thr_abs_q = data[amvl_pkg::LEVEL_W-1:0];
         amvl_pkg::CSR_THRESH_REL: thr_rel_q = data[amvl_pkg::REL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic add_word(bit rep, logic [15:0] x, logic [15:0] y, logic [15:0] z, bit f);
      sample_word_type w;
      w.is_report = rep;
      w.xw = x;
      w.yw = y;
      w.zw = z;
      w.force_rep = f;
      pending_words = {pending_words, w};
   endtask

   task automatic add_random(int n, int report_pct);
      repeat (n)
         add_word($urandom_range(99) < report_pct, 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom_range(1)));
   endtask

   // Wait for all words to go through and the sequencer to settle
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_chan.valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [amvl_pkg::CSR_DATA_W-1:0] data;
      held = 0;
      level_q = 0;
      last_rep_q = 0;
      off_x = 0;
      off_y = 0;
      off_z = 0;
      alpha_q = amvl_pkg::ALPHA_RESET;
      thr_abs_q = 0;
      thr_rel_q = 0;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed: reports on an empty window, extremes, ignored flags and words
      add_word(1, 16'h0000, 16'h0000, 16'h0000, 0);
      add_word(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
      add_word(0, 16'h7FF0, 16'h8000, 16'h0000, 1);
      add_word(1, 16'h0000, 16'h0000, 16'h0000, 0);
      add_word(0, 16'hFFFF, 16'h000F, 16'h7FFF, 0);
      add_word(0, 16'h8000, 16'h7FF0, 16'hFFF0, 0);
      add_word(0, 16'h0010, 16'hFFEF, 16'h8000, 0);
      add_word(0, 16'h7FF0, 16'h7FF0, 16'h7FF0, 0);
      add_word(1, 16'h1234, 16'h5678, 16'h9ABC, 0);
      add_word(0, 16'h8000, 16'h8000, 16'h8000, 0);
      add_word(0, 16'h8000, 16'h8000, 16'h8000, 0);
      add_word(0, 16'h8000, 16'h8000, 16'h8000, 0);
      add_word(1, 16'h0000, 16'h0000, 16'h0000, 0);
      add_word(1, 16'h0000, 16'h0000, 16'h0000, 1);
      add_word(0, 16'h00A0, 16'h0000, 16'h0000, 0);
      add_word(1, 16'h0000, 16'h0000, 16'h0000, 0);
      wait_idle();

      // Phases over several register settings, extremes first
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_reg(amvl_pkg::CSR_OFFSET_X, 29'h800);
               write_reg(amvl_pkg::CSR_OFFSET_Y, 29'h7FF);
               write_reg(amvl_pkg::CSR_OFFSET_Z, 29'h800);
               write_reg(amvl_pkg::CSR_ALPHA, 29'hFFFF);
               write_reg(amvl_pkg::CSR_THRESH_ABS, 29'h0);
               write_reg(amvl_pkg::CSR_THRESH_REL, 29'h0);
            end
            1: begin
               write_reg(amvl_pkg::CSR_OFFSET_X, 29'h7FF);
               write_reg(amvl_pkg::CSR_OFFSET_Y, 29'h800);
               write_reg(amvl_pkg::CSR_OFFSET_Z, 29'h7FF);
               write_reg(amvl_pkg::CSR_ALPHA, 29'h0);
               write_reg(amvl_pkg::CSR_THRESH_ABS, 29'h1FFF_FFFF);
               write_reg(amvl_pkg::CSR_THRESH_REL, 29'hFFFF);
            end
            default: begin
               // Out-of-range indexes must be ignored
               write_reg(CSR_UNUSED_A, 29'($urandom));
               write_reg(CSR_UNUSED_B, 29'($urandom));
               for (int r = 0; r <= int'(amvl_pkg::CSR_THRESH_REL); r++) begin
                  data = 29'($urandom);
                  if (r == int'(amvl_pkg::CSR_THRESH_ABS)) data = 29'($urandom_range(20 << 16));
                  if (r == int'(amvl_pkg::CSR_ALPHA) && ph == 2) data = 29'h8000;
                  write_reg(amvl_pkg::CSR_IDX_W'(r), data);
               end
            end
         endcase
         steady = (ph == 3);
         add_random(90, 20);
         // Receiver holds off while reports pile up
         if (ph == 4) begin
            while (pending_words.size() > 0) @(posedge clock);
            hold_trigger = hold_trigger + 1;
            add_random(40, 70);
         end
         add_random(90, 20);
         wait_idle();
      end

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
